@@ rtl/core/ipt_pkg.sv @@
// Shared types, codes and helper functions for the IPv4 prefix table.
package ipt_pkg;

    // Operation codes carried on the op port.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned AGE_W   = 32;
    localparam int unsigned CNT_W   = 32;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    // One table slot as held in the entry memory.
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [AGE_W-1:0]  age;
    } entry_t;

    // Per-entry evaluation handed from the match unit to the control.
    typedef struct packed {
        logic             is_free;
        logic             del_hit;
        logic             srch_hit;
        logic [AGE_W-1:0] age_gap;
    } match_t;

    // Mask that keeps the leading len bits of an address.
    function automatic logic [ADDR_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
        lead_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

    // Lengths above 32 are saturated to 32.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        clamp_len = (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

endpackage

@@ rtl/core/ipt_entry_mem.sv @@
// Single-port-write, registered-read memory that holds the table entries.
module ipt_entry_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_W = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  ipt_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_idx,
    output ipt_pkg::entry_t       rd_data
);

    ipt_pkg::entry_t mem [DEPTH];
    ipt_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ipt_entry_match.sv @@
// Evaluates one entry read from memory against the current operation.
module ipt_entry_match (
    input  ipt_pkg::entry_t                    entry,
    input  logic [ipt_pkg::ADDR_W-1:0]         key,
    input  logic [ipt_pkg::LEN_W-1:0]          len,
    input  logic [ipt_pkg::AGE_W-1:0]          insert_seq,
    output ipt_pkg::match_t                    result
);

    logic [ipt_pkg::ADDR_W-1:0] diff;

    // Address bits that differ, limited to the entry's own prefix.
    assign diff = (entry.addr ^ key) & ipt_pkg::lead_mask(entry.len);

    // Free slot, exact delete match, covering prefix and age distance.
    assign result.is_free  = ~entry.valid;
    assign result.del_hit  = entry.valid && (entry.addr == key) && (entry.len == len);
    assign result.srch_hit = entry.valid && (diff == '0);
    assign result.age_gap  = insert_seq - entry.age;

endmodule

@@ rtl/core/ipv4_prefix_table_top.sv @@
// Top level of the IPv4 prefix table: command port, scan control and counters.
//
// Usage: drive op, address and prefix_len and raise start; the command is a
// transfer at the rising edge where start is high and busy is low. Insert
// stores the prefix in the lowest free slot, delete frees the oldest slot
// with equal address and length, search reports whether any stored prefix
// covers the address and advances the hit or miss count.
// Every command gives exactly one result: done is high for one cycle and
// status, hit, hit_total and miss_total are valid in that cycle. The
// receiver cannot hold the result off; it must take it in that cycle.
// Operation: every command scans all TABLE_ENTRIES slots through the entry
// memory, one read per cycle, then writes back and counts in S_FINISH;
// done rises after S_FINISH, and busy falls in the done cycle. A new
// command is taken only after the previous one has given its result; the
// scan over the single memory read port sets this.
// Reset: rst_n clears the counters and the insertion sequence, then the
// block runs a clearing pass over all TABLE_ENTRIES memory slots with
// busy high before it takes its first command.
module ipv4_prefix_table_top #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    output logic        done,
    output logic [1:0]  status,
    output logic        hit,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CTR_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CTR_W-1:0] LAST_CNT = CTR_W'(TABLE_ENTRIES - 1);
    localparam logic [CTR_W-1:0] END_CNT  = CTR_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                         state_reg;
    logic [CTR_W-1:0]               cnt_reg;
    logic                           cmp_vld_reg;
    logic [IDX_W-1:0]               cmp_idx_reg;
    ipt_pkg::op_t                   op_reg;
    logic [ipt_pkg::ADDR_W-1:0]     key_reg;
    logic [ipt_pkg::LEN_W-1:0]      len_reg;
    logic                           free_found_reg;
    logic [IDX_W-1:0]               free_idx_reg;
    logic                           best_found_reg;
    logic [IDX_W-1:0]               best_idx_reg;
    logic [ipt_pkg::AGE_W-1:0]      best_dist_reg;
    logic                           srch_hit_reg;
    logic [ipt_pkg::AGE_W-1:0]      insert_seq_reg;
    logic [ipt_pkg::CNT_W-1:0]      hit_cnt_reg;
    logic [ipt_pkg::CNT_W-1:0]      miss_cnt_reg;
    logic                           done_reg;
    ipt_pkg::status_t               status_reg;
    logic                           hit_reg;

    logic                           mem_wr_en;
    logic [IDX_W-1:0]               mem_wr_idx;
    ipt_pkg::entry_t                mem_wr_data;
    logic                           mem_rd_en;
    ipt_pkg::entry_t                mem_rd_data;
    ipt_pkg::match_t                match;
    logic                           better;

    // Entry storage.
    ipt_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (cnt_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    // Compare of the entry that just came out of memory.
    ipt_entry_match u_match (
        .entry      (mem_rd_data),
        .key        (key_reg),
        .len        (len_reg),
        .insert_seq (insert_seq_reg),
        .result     (match)
    );

    // A matching delete candidate replaces the best one only if strictly older.
    assign better = match.del_hit && (!best_found_reg || (match.age_gap > best_dist_reg));

    // Memory read issue during the scan.
    assign mem_rd_en = (state_reg == S_SCAN) && (cnt_reg < END_CNT);

    // Memory writes: clearing pass, stored insert or freed slot.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_idx  = cnt_reg[IDX_W-1:0];
        mem_wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
            end
            S_FINISH:
            begin
                if (op_reg == ipt_pkg::OP_INSERT)
                begin
                    mem_wr_en         = free_found_reg;
                    mem_wr_idx        = free_idx_reg;
                    mem_wr_data.valid = 1'b1;
                    mem_wr_data.len   = len_reg;
                    mem_wr_data.addr  = key_reg;
                    mem_wr_data.age   = insert_seq_reg;
                end
                else if (op_reg == ipt_pkg::OP_DELETE)
                begin
                    mem_wr_en  = best_found_reg;
                    mem_wr_idx = best_idx_reg;
                end
            end
            S_IDLE, S_SCAN:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // Control state, scan bookkeeping, counters and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            op_reg         <= ipt_pkg::OP_NONE;
            key_reg        <= '0;
            len_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            srch_hit_reg   <= 1'b0;
            insert_seq_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            done_reg       <= 1'b0;
            status_reg     <= ipt_pkg::ST_OK;
            hit_reg        <= 1'b0;
        end
        else
        begin
            // The result strobe follows the write-back cycle.
            done_reg <= (state_reg == S_FINISH);
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (cnt_reg == LAST_CNT)
                    begin
                        state_reg <= S_IDLE;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg      <= S_SCAN;
                        cnt_reg        <= '0;
                        cmp_vld_reg    <= 1'b0;
                        op_reg         <= ipt_pkg::op_t'(op);
                        key_reg        <= address;
                        len_reg        <= ipt_pkg::clamp_len(prefix_len);
                        free_found_reg <= 1'b0;
                        best_found_reg <= 1'b0;
                        srch_hit_reg   <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // Issue side: one read per cycle until every slot is read.
                    if (cnt_reg < END_CNT)
                    begin
                        cnt_reg     <= cnt_reg + 1'b1;
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= cnt_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                    end
                    // Compare side: fold in the entry read the cycle before.
                    if (cmp_vld_reg)
                    begin
                        if (match.is_free && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                        if (better)
                        begin
                            best_found_reg <= 1'b1;
                            best_idx_reg   <= cmp_idx_reg;
                            best_dist_reg  <= match.age_gap;
                        end
                        if (match.srch_hit)
                        begin
                            srch_hit_reg <= 1'b1;
                        end
                        // The last compare coincides with the issue side running out.
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    unique case (op_reg)
                        ipt_pkg::OP_INSERT:
                        begin
                            hit_reg <= 1'b0;
                            if (free_found_reg)
                            begin
                                status_reg     <= ipt_pkg::ST_OK;
                                insert_seq_reg <= insert_seq_reg + 1'b1;
                            end
                            else
                            begin
                                status_reg <= ipt_pkg::ST_FULL;
                            end
                        end
                        ipt_pkg::OP_DELETE:
                        begin
                            hit_reg <= 1'b0;
                            if (best_found_reg)
                            begin
                                status_reg <= ipt_pkg::ST_OK;
                            end
                            else
                            begin
                                status_reg <= ipt_pkg::ST_NOT_FOUND;
                            end
                        end
                        ipt_pkg::OP_SEARCH:
                        begin
                            status_reg <= ipt_pkg::ST_OK;
                            hit_reg    <= srch_hit_reg;
                            if (srch_hit_reg)
                            begin
                                hit_cnt_reg <= hit_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                miss_cnt_reg <= miss_cnt_reg + 1'b1;
                            end
                        end
                        ipt_pkg::OP_NONE:
                        begin
                            status_reg <= ipt_pkg::ST_OK;
                            hit_reg    <= 1'b0;
                        end
                    endcase
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign hit        = hit_reg;
    assign hit_total  = hit_cnt_reg;
    assign miss_total = miss_cnt_reg;

    // A result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    // The block is ready again in the cycle it reports a result.
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result reported while still busy");

    // An accepted command makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done_reg))
        else $error("command transfer did not start a scan");

    // A search hit always comes with an ok status.
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (status_reg == ipt_pkg::ST_OK))
        else $error("hit reported with an error status");

    // A full report means the scan found no free slot.
    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ipt_pkg::ST_FULL)) |-> !free_found_reg)
        else $error("table full reported although a free slot was seen");

endmodule
